[rtl/ppt_pkg.sv]
// shared types and constants for the pairwise preference tally
// no dependencies; imported by every rtl module of the block

package ppt_pkg;

	localparam int CANDIDATES  = 8;
	localparam int COUNT_WIDTH = 16;

	// fixed field widths
	localparam int IDX_W      = 3;
	localparam int CCOUNT_W   = 4;
	localparam int OUT_CNT_W  = 16;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [CCOUNT_W-1:0] CC_MIN   = CCOUNT_W'(2);
	localparam logic [CCOUNT_W-1:0] CC_MAX   = CCOUNT_W'(CANDIDATES);
	localparam logic [CCOUNT_W-1:0] CC_RESET = CCOUNT_W'((CANDIDATES < 8) ? CANDIDATES : 8);

	typedef enum logic [1:0] {
		CMD_BALLOT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_INDEX  = 2'd1,
		ST_REPEAT = 2'd2,
		ST_LENGTH = 2'd3
	} status_t;

	// update request from the command decoder to the counter matrix
	typedef struct packed {
		logic                  clear;
		logic                  inc_en;
		logic [CANDIDATES-1:0] inc_rows;
		logic [IDX_W-1:0]      inc_col;
	} mat_ctl_t;

endpackage

[rtl/ppt_matrix.sv]
// matrix of saturating preference counters with a per-column parallel increment
// depends on ppt_pkg

module ppt_matrix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ppt_pkg::mat_ctl_t              ctl,
	input  logic [ppt_pkg::IDX_W-1:0]      rd_row,
	input  logic [ppt_pkg::IDX_W-1:0]      rd_col,
	output logic [ppt_pkg::COUNT_WIDTH-1:0] rd_data
);
	import ppt_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] cell_q [CANDIDATES][CANDIDATES];

	for (genvar p = 0; p < CANDIDATES; p++) begin : g_row
		for (genvar c = 0; c < CANDIDATES; c++) begin : g_col
			logic hit;
			assign hit = ctl.inc_en && ctl.inc_rows[p] && (ctl.inc_col == IDX_W'(c));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cell_q[p][c] <= '0;
				end else if (ctl.clear) begin
					cell_q[p][c] <= '0;
				end else if (hit && (cell_q[p][c] != CNT_MAX)) begin
					cell_q[p][c] <= cell_q[p][c] + COUNT_WIDTH'(1);
				end
			end
		end
	end

	assign rd_data = cell_q[rd_row][rd_col];

endmodule

[rtl/ppt_ctrl.sv]
// command decode, open-ballot tracking and status for one item
// depends on ppt_pkg

module ppt_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         exec,
	input  ppt_pkg::cmd_t                cmd,
	input  logic [ppt_pkg::IDX_W-1:0]    cand,
	input  logic                         last,
	input  logic [ppt_pkg::IDX_W-1:0]    row,
	input  logic [ppt_pkg::IDX_W-1:0]    col,
	input  logic [ppt_pkg::CCOUNT_W-1:0] cand_count,
	output ppt_pkg::mat_ctl_t            mctl,
	output ppt_pkg::status_t             status,
	output logic                         rd_ok
);
	import ppt_pkg::*;

	logic [CANDIDATES-1:0] mask_q, mask_d;
	logic [CCOUNT_W-1:0]   pos_q, pos_d;
	logic                  cand_bad, cand_rep, cand_ok;

	assign cand_bad = CCOUNT_W'(cand) >= cand_count;
	assign cand_rep = mask_q[cand];
	assign cand_ok  = !cand_bad && !cand_rep;

	always_comb begin
		mask_d        = mask_q;
		pos_d         = pos_q;
		status        = ST_OK;
		rd_ok         = 1'b0;
		mctl.clear    = 1'b0;
		mctl.inc_en   = 1'b0;
		mctl.inc_rows = mask_q;
		mctl.inc_col  = cand;
		unique case (cmd)
			CMD_BALLOT: begin
				if (cand_bad) begin
					status = ST_INDEX;
				end else if (cand_rep) begin
					status = ST_REPEAT;
				end else begin
					mctl.inc_en = exec;
					mask_d      = mask_q | (CANDIDATES'(1) << cand);
					pos_d       = pos_q + CCOUNT_W'(1);
				end
				// the last element always closes the ballot, even when ignored
				if (last) begin
					if (cand_ok && (pos_d != cand_count)) begin
						status = ST_LENGTH;
					end
					mask_d = '0;
					pos_d  = '0;
				end
			end
			CMD_READ: begin
				if ((CCOUNT_W'(row) >= cand_count) || (CCOUNT_W'(col) >= cand_count)) begin
					status = ST_INDEX;
				end else begin
					rd_ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				mctl.clear = exec;
				mask_d     = '0;
				pos_d      = '0;
			end
			CMD_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			pos_q  <= '0;
		end else if (exec) begin
			mask_q <= mask_d;
			pos_q  <= pos_d;
		end
	end

endmodule

[rtl/pairwise_preference_tally.sv]
// pairwise preference tally: ranked ballots into a saturating pairwise count matrix
// an accepted item is held in the input register, and its result is then held in the result register
// throughput: one item per cycle while m_tready does not hold back a result
// reset clears the counter matrix and the open ballot, candidate_count returns to 8
// depends on ppt_pkg, ppt_ctrl and ppt_matrix

module pairwise_preference_tally (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ppt_pkg::CCOUNT_W-1:0]     cfg_data,   // candidate_count
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ppt_pkg::IN_DATA_W-1:0]    s_tdata,    // cmd, candidate, row, col, zero pad
	input  logic                             s_tlast,    // last_of_ballot
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ppt_pkg::OUT_DATA_W-1:0]   m_tdata     // count, status, zero pad
);
	import ppt_pkg::*;

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [IDX_W-1:0]      cand_s1, row_s1, col_s1;
	logic                  last_s1;

	logic [CCOUNT_W-1:0]   cc_q;
	logic                  out_valid_q;
	logic [OUT_CNT_W-1:0]  out_count_q;
	status_t               out_status_q;

	logic                  out_free, exec;
	mat_ctl_t              mctl;
	status_t               status;
	logic                  rd_ok;
	logic [COUNT_WIDTH-1:0] rd_data;

	assign out_free = !out_valid_q || m_tready;
	assign exec     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// clamp the register into the legal candidate range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_RESET;
		end else if (cfg_we) begin
			if (cfg_data > CC_MAX) begin
				cc_q <= CC_MAX;
			end else if (cfg_data < CC_MIN) begin
				cc_q <= CC_MIN;
			end else begin
				cc_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= cmd_t'(s_tdata[1:0]);
			cand_s1 <= s_tdata[4:2];
			row_s1  <= s_tdata[7:5];
			col_s1  <= s_tdata[10:8];
			last_s1 <= s_tlast;
		end
	end

	ppt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.exec       (exec),
		.cmd        (cmd_s1),
		.cand       (cand_s1),
		.last       (last_s1),
		.row        (row_s1),
		.col        (col_s1),
		.cand_count (cc_q),
		.mctl       (mctl),
		.status     (status),
		.rd_ok      (rd_ok)
	);

	ppt_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mctl),
		.rd_row  (row_s1),
		.rd_col  (col_s1),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_count_q  <= rd_ok ? OUT_CNT_W'(rd_data) : '0;
			out_status_q <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_status_q, out_count_q};

	// the register never leaves its legal range
	a_cc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cc_q >= CC_MIN) && (cc_q <= CC_MAX))
		else $error("candidate_count out of range");

	// an executed item always shows up as a result on the next cycle
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> m_tvalid)
		else $error("executed item produced no result");

	// input stalls only while an item waits in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a pending item");

	// counts move only for a fresh candidate, never on a bad or repeated one
	a_inc_status: assert property (@(posedge clk) disable iff (!arst_n)
		mctl.inc_en |-> ((status == ST_OK) || (status == ST_LENGTH)))
		else $error("increment with error status");

	// a clear and an increment never happen together
	a_clear_inc: assert property (@(posedge clk) disable iff (!arst_n)
		mctl.clear |-> !mctl.inc_en)
		else $error("clear and increment in the same cycle");

endmodule
